// ----- design/gbe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbe_pkg
// Shared types and constants for the gap buffer edit engine.
// ----------------------------------------------------------------------------
package gbe_pkg;

  localparam int CAPACITY = 4096;
  localparam int AW = $clog2(CAPACITY);
  localparam int PW = 13;

  localparam logic [7:0] NEWLINE = 8'h0A;

  localparam logic [3:0] MODE_INSERT = 4'd0;
  localparam logic [3:0] MODE_BKSP   = 4'd1;
  localparam logic [3:0] MODE_DEL    = 4'd2;
  localparam logic [3:0] MODE_LEFT   = 4'd3;
  localparam logic [3:0] MODE_RIGHT  = 4'd4;
  localparam logic [3:0] MODE_HOME   = 4'd5;
  localparam logic [3:0] MODE_END    = 4'd6;
  localparam logic [3:0] MODE_UP     = 4'd7;
  localparam logic [3:0] MODE_DOWN   = 4'd8;
  localparam logic [3:0] MODE_SET    = 4'd9;
  localparam logic [3:0] MODE_READ   = 4'd10;

  typedef enum logic [3:0] {
    OP_INSERT = 4'd0,
    OP_BKSP   = 4'd1,
    OP_DEL    = 4'd2,
    OP_LEFT   = 4'd3,
    OP_RIGHT  = 4'd4,
    OP_HOME   = 4'd5,
    OP_END    = 4'd6,
    OP_UP     = 4'd7,
    OP_DOWN   = 4'd8,
    OP_SET    = 4'd9,
    OP_READ   = 4'd10,
    OP_NOP    = 4'd15
  } op_t;

  typedef struct packed {
    op_t            op;
    logic [7:0]     ch;
    logic [PW-1:0]  pos;
    logic [PW-1:0]  cnt;
  } cmd_t;

endpackage

// ----- design/gap_buffer_edit_engine_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gap_buffer_edit_engine_core
// Text edit engine holding up to 4096 bytes as a gap buffer with a cursor.
// ----------------------------------------------------------------------------
// One command is worked at a time. Cursor moves scan bytes and carry bytes
// across the gap one at a time, since all work goes through the single read
// and single write port of the text store; home, end, up, down and set cursor
// thus scale with the distance walked. A two-item queue lets new items be taken
// while a command is in progress, and a full store refuses inserts with
// full_error set.
module gap_buffer_edit_engine_core import gbe_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [3:0]     mode,
  input  logic [7:0]     char_in,
  input  logic [PW-1:0]  position,
  input  logic [PW-1:0]  line_count,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     read_byte,
  output logic [PW-1:0]  cursor_pos,
  output logic [PW-1:0]  text_length,
  output logic           full_error
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  gbe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .char_in    (char_in),
    .position   (position),
    .line_count (line_count),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd)
  );

  gbe_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .read_byte   (read_byte),
    .cursor_pos  (cursor_pos),
    .text_length (text_length),
    .full_error  (full_error)
  );

endmodule

// ----- design/gbe_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbe_front
// Accepts items, decodes the mode and queues commands for the back end.
// ----------------------------------------------------------------------------
module gbe_front import gbe_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [3:0]     mode,
  input  logic [7:0]     char_in,
  input  logic [PW-1:0]  position,
  input  logic [PW-1:0]  line_count,
  output logic           cmd_valid,
  input  logic           cmd_ready,
  output cmd_t           cmd
);

  cmd_t       q [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  op_t        op_dec;
  logic       push;
  logic       pop;

  always_comb begin
    unique case (mode)
      MODE_INSERT: op_dec = OP_INSERT;
      MODE_BKSP:   op_dec = OP_BKSP;
      MODE_DEL:    op_dec = OP_DEL;
      MODE_LEFT:   op_dec = OP_LEFT;
      MODE_RIGHT:  op_dec = OP_RIGHT;
      MODE_HOME:   op_dec = OP_HOME;
      MODE_END:    op_dec = OP_END;
      MODE_UP:     op_dec = OP_UP;
      MODE_DOWN:   op_dec = OP_DOWN;
      MODE_SET:    op_dec = OP_SET;
      MODE_READ:   op_dec = OP_READ;
      default:     op_dec = OP_NOP;
    endcase
  end

  assign in_ready  = (cnt != 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q[rp];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= '{op: op_dec, ch: char_in, pos: position, cnt: line_count};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      if (push && !pop) cnt <= cnt + 2'd1;
      else if (pop && !push) cnt <= cnt - 2'd1;
    end
  end

endmodule

// ----- design/gbe_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbe_back
// Executes commands on the gap buffer store and holds the result register.
// ----------------------------------------------------------------------------
module gbe_back import gbe_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  cmd_t           cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     read_byte,
  output logic [PW-1:0]  cursor_pos,
  output logic [PW-1:0]  text_length,
  output logic           full_error
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_LS   = 8'b0000_0010,
    S_UP   = 8'b0000_0100,
    S_COL  = 8'b0000_1000,
    S_DN   = 8'b0001_0000,
    S_MOVE = 8'b0010_0000,
    S_READ = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  localparam logic [PW-1:0] CAP = PW'(CAPACITY);

  state_t         state;
  logic           ph;
  op_t            op;
  logic [PW-1:0]  gs;
  logic [PW-1:0]  ge;
  logic [PW-1:0]  i;
  logic [PW-1:0]  c;
  logic [PW-1:0]  n;
  logic [PW-1:0]  ll;
  logic [PW-1:0]  tgt;
  logic           found;
  logic           err;
  logic [7:0]     rd;

  logic [7:0]     mem [CAPACITY];
  logic [7:0]     rdata;
  logic [AW-1:0]  raddr;
  logic [AW-1:0]  waddr;
  logic [7:0]     wdata;
  logic           we;

  logic [PW-1:0]  gap;
  logic [PW-1:0]  len;
  logic [PW-1:0]  gs_m1;
  logic [PW-1:0]  ge_m1;
  logic [PW-1:0]  i_m1;
  logic [PW-1:0]  i_m2;
  logic           is_nl;
  logic           ls_done;
  logic           out_free;

  function automatic logic [AW-1:0] phys(logic [PW-1:0] j, logic [PW-1:0] s,
                                         logic [PW-1:0] g);
    logic [PW-1:0] t;
    t = (j < s) ? j : j + g;
    return t[AW-1:0];
  endfunction

  assign gap      = ge - gs;
  assign len      = CAP - gap;
  assign gs_m1    = gs - 1'b1;
  assign ge_m1    = ge - 1'b1;
  assign i_m1     = i - 1'b1;
  assign i_m2     = i - 2'd2;
  assign is_nl    = (rdata == NEWLINE);
  assign ls_done  = ph ? is_nl : (i == '0);
  assign out_free = !out_valid || out_ready;
  assign cmd_ready = (state == S_IDLE);

  always_comb begin
    unique case (state)
      S_LS:    raddr = phys(i_m1, gs, gap);
      S_UP:    raddr = phys(i_m2, gs, gap);
      S_COL:   raddr = phys(i, gs, gap);
      S_DN:    raddr = phys(i, gs, gap);
      S_READ:  raddr = phys(i, gs, gap);
      S_MOVE:  raddr = (gs > tgt) ? gs_m1[AW-1:0] : ge[AW-1:0];
      default: raddr = '0;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = gs[AW-1:0];
    wdata = cmd.ch;
    if (state == S_IDLE) begin
      we = cmd_valid && (cmd.op == OP_INSERT) && (gs != ge);
    end else if (state == S_MOVE && ph) begin
      we    = 1'b1;
      waddr = (gs > tgt) ? ge_m1[AW-1:0] : gs[AW-1:0];
      wdata = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ph        <= 1'b0;
      gs        <= '0;
      ge        <= CAP;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_OUT) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            op    <= cmd.op;
            err   <= 1'b0;
            rd    <= '0;
            ph    <= 1'b0;
            state <= S_OUT;
            case (cmd.op)
              OP_INSERT: begin
                if (gs == ge) err <= 1'b1;
                else gs <= gs + 1'b1;
              end
              OP_BKSP: if (gs != '0) gs <= gs_m1;
              OP_DEL: if (ge < CAP) ge <= ge + 1'b1;
              OP_LEFT: begin
                if (gs != '0) begin
                  tgt   <= gs_m1;
                  state <= S_MOVE;
                end
              end
              OP_RIGHT: begin
                if (ge < CAP) begin
                  tgt   <= gs + 1'b1;
                  state <= S_MOVE;
                end
              end
              OP_HOME, OP_UP, OP_DOWN: begin
                i     <= gs;
                c     <= '0;
                n     <= cmd.cnt;
                state <= S_LS;
              end
              OP_END: begin
                i     <= gs;
                c     <= '1;
                state <= S_COL;
              end
              OP_SET: begin
                tgt   <= (cmd.pos > len) ? len : cmd.pos;
                state <= S_MOVE;
              end
              OP_READ: begin
                if (cmd.pos < len) begin
                  i     <= cmd.pos;
                  state <= S_READ;
                end
              end
              default: ;
            endcase
          end
        end
        S_LS: begin
          if (ls_done) begin
            ph <= 1'b0;
            case (op)
              OP_HOME: begin
                tgt   <= i;
                state <= S_MOVE;
              end
              OP_UP: begin
                if (i == '0 || n == '0) state <= S_OUT;
                else state <= S_UP;
              end
              default: begin
                if (n == '0) state <= S_OUT;
                else begin
                  ll    <= i;
                  i     <= gs;
                  found <= 1'b0;
                  state <= S_DN;
                end
              end
            endcase
          end else if (!ph) begin
            ph <= 1'b1;
          end else begin
            i  <= i_m1;
            c  <= c + 1'b1;
            ph <= 1'b0;
          end
        end
        S_UP: begin
          if (!ph) begin
            if (n == '0) state <= S_COL;
            else if (i_m1 == '0) begin
              i     <= '0;
              state <= S_COL;
            end else begin
              i  <= i_m1;
              ph <= 1'b1;
            end
          end else begin
            if (is_nl) n <= n - 1'b1;
            ph <= 1'b0;
          end
        end
        S_COL: begin
          if (!ph) begin
            if (c == '0 || i >= len) begin
              tgt   <= i;
              state <= S_MOVE;
            end else begin
              ph <= 1'b1;
            end
          end else begin
            ph <= 1'b0;
            if (is_nl) begin
              tgt   <= i;
              state <= S_MOVE;
            end else begin
              i <= i + 1'b1;
              c <= c - 1'b1;
            end
          end
        end
        S_DN: begin
          if (!ph) begin
            if (n == '0) state <= S_COL;
            else if (i >= len) begin
              if (found) begin
                tgt   <= ll;
                state <= S_MOVE;
              end else begin
                state <= S_OUT;
              end
            end else begin
              ph <= 1'b1;
            end
          end else begin
            if (is_nl) begin
              n     <= n - 1'b1;
              ll    <= i + 1'b1;
              found <= 1'b1;
            end
            i  <= i + 1'b1;
            ph <= 1'b0;
          end
        end
        S_MOVE: begin
          if (!ph) begin
            if (gs == tgt) state <= S_OUT;
            else ph <= 1'b1;
          end else begin
            ph <= 1'b0;
            if (gs > tgt) begin
              gs <= gs_m1;
              ge <= ge_m1;
            end else begin
              gs <= gs + 1'b1;
              ge <= ge + 1'b1;
            end
          end
        end
        S_READ: begin
          if (!ph) ph <= 1'b1;
          else begin
            ph    <= 1'b0;
            rd    <= rdata;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            read_byte   <= rd;
            cursor_pos  <= gs;
            text_length <= len;
            full_error  <= err;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- design/gbe_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbe_checker
// Port-level checks for the gap buffer edit engine.
// ----------------------------------------------------------------------------
module gbe_checker import gbe_pkg::*; (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input logic [3:0]     mode,
  input logic [7:0]     char_in,
  input logic [PW-1:0]  position,
  input logic [PW-1:0]  line_count,
  input logic           out_valid,
  input logic           out_ready,
  input logic [7:0]     read_byte,
  input logic [PW-1:0]  cursor_pos,
  input logic [PW-1:0]  text_length,
  input logic           full_error
);

  localparam logic [PW-1:0] CAP = PW'(CAPACITY);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(cursor_pos) && $stable(text_length))
    else $error("result changed while stalled");

  a_bounds: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> text_length <= CAP && cursor_pos <= text_length)
    else $error("cursor or length out of range");

  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && full_error |-> text_length == CAP && read_byte == 8'd0)
    else $error("full flag without a full store");

endmodule

bind gap_buffer_edit_engine_core gbe_checker u_chk (.*);
